### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/les_pkg.sv
`timescale 1ns / 1ps

package les_pkg;

    // Default number format: signed Q8.24
    localparam int LES_FRAC_BITS   = 24;
    localparam int LES_COORD_WIDTH = 32;

    // Register and field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int PARAM_W    = 31;
    localparam int DT_W       = 25;
    localparam int IDX_W      = 16;
    localparam int COLOR_W    = 2;
    localparam int SEG_NUM_W  = 3;

    // Width of one multiplier slice
    localparam int MUL_CHUNK = 16;

    // Register reset values
    localparam logic [PARAM_W-1:0] RHO_RST    = 31'd469762048;
    localparam logic [PARAM_W-1:0] SIGMA_RST  = 31'd167772160;
    localparam logic [PARAM_W-1:0] BETA_RST   = 31'd44739243;
    localparam logic [DT_W-1:0]    DT_RST     = 25'd16777;
    localparam logic [IDX_W-1:0]   MARKER_RST = 16'd100;
    localparam logic [IDX_W-1:0]   SEGLEN_RST = 16'd10000;
    localparam logic [IDX_W-1:0]   RUNLEN_RST = 16'd50000;

    // Segment counter tops out here (two segments per color)
    localparam logic [SEG_NUM_W-1:0] SEG_NUM_MAX = 3'd5;

    // Color codes
    localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RHO,
        CFG_SIGMA,
        CFG_BETA,
        CFG_DT,
        CFG_MARKER,
        CFG_SEGLEN,
        CFG_RUNLEN
    } t_cfg_idx;

    // Multiply operations of one Euler step, in issue order
    typedef enum logic [2:0] {
        MOP_SIGMA_DX,
        MOP_X_RHO,
        MOP_X_Y,
        MOP_BETA_Z,
        MOP_DT_DX,
        MOP_DT_DY,
        MOP_DT_DZ
    } t_mop;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_NORM,
        S_WB,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic mul_start;
        logic mul_step;
        logic norm;
        logic wb;
        logic commit;
        t_mop op;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mul_last;
        logic out_free;
    } t_sts;

    function automatic t_mop next_mop(input t_mop op);
        t_mop nxt;
        case (op)
            MOP_SIGMA_DX: nxt = MOP_X_RHO;
            MOP_X_RHO:    nxt = MOP_X_Y;
            MOP_X_Y:      nxt = MOP_BETA_Z;
            MOP_BETA_Z:   nxt = MOP_DT_DX;
            MOP_DT_DX:    nxt = MOP_DT_DY;
            MOP_DT_DY:    nxt = MOP_DT_DZ;
            default:      nxt = MOP_SIGMA_DX;
        endcase
        return nxt;
    endfunction

endpackage

### design/les_ctrl.sv
`timescale 1ns / 1ps

module les_ctrl
    import les_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_mop   r_op, n_op;

    // state and operation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MOP_SIGMA_DX;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                    n_op    = MOP_SIGMA_DX;
                end
            end
            S_START: n_state = S_MUL;
            S_MUL: begin
                if (i_sts.mul_last) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: n_state = S_WB;
            S_WB: begin
                if (r_op == MOP_DT_DZ) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_START;
                    n_op    = next_mop(r_op);
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            S_START: o_cmd.mul_start = 1'b1;
            S_MUL:   o_cmd.mul_step  = 1'b1;
            S_NORM:  o_cmd.norm      = 1'b1;
            S_WB:    o_cmd.wb        = 1'b1;
            S_DONE:  o_cmd.commit    = i_sts.out_free;
            default: o_in_stall      = 1'b1;
        endcase
    end

endmodule

### design/les_datapath.sv
`timescale 1ns / 1ps

module les_datapath
    import les_pkg::*;
#(
    parameter int FRAC_BITS   = LES_FRAC_BITS,
    parameter int COORD_WIDTH = LES_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_restart,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z,
    output logic [IDX_W-1:0]              o_step_index,
    output logic [COLOR_W-1:0]            o_color_code,
    output logic                          o_marker_hit,
    output logic                          o_last_of_run,
    output logic                          o_overflow_flag
);

    localparam int CW    = COORD_WIDTH;
    // operand magnitude: coordinate or 31-bit register, whichever is wider
    localparam int OP_W  = (COORD_WIDTH > PARAM_W) ? COORD_WIDTH : PARAM_W;
    localparam int XW    = OP_W + 2;
    localparam int NCH   = (OP_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BW    = NCH * MUL_CHUNK;
    localparam int PW    = OP_W + BW;
    localparam int QW    = PW - FRAC_BITS;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic signed [XW-1:0] CMAX_X = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] CMIN_X = ~CMAX_X;
    localparam logic [QW-1:0] LIM_POS = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = LIM_POS + QW'(1);
    localparam logic [CW-1:0] ONE_C   = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // sign-extend a coordinate to the working width
    function automatic logic signed [XW-1:0] sx(input logic signed [CW-1:0] v);
        return XW'(v);
    endfunction

    // clamp to coordinate range; MSB of the result is the clamp flag
    function automatic logic [CW:0] sat_c(input logic signed [XW-1:0] v);
        if (v > CMAX_X) begin
            return {1'b1, CMAX_X[CW-1:0]};
        end else if (v < CMIN_X) begin
            return {1'b1, CMIN_X[CW-1:0]};
        end else begin
            return {1'b0, v[CW-1:0]};
        end
    endfunction

    function automatic logic [OP_W-1:0] mag(input logic signed [XW-1:0] v);
        logic [XW-1:0] t;
        t = v[XW-1] ? -v : v;
        return t[OP_W-1:0];
    endfunction

    // configuration registers
    logic [PARAM_W-1:0] r_rho, r_sigma, r_beta;
    logic [DT_W-1:0]    r_dt;
    logic [IDX_W-1:0]   r_marker, r_seglen, r_runlen;

    // point, derivatives, new point
    logic [CW-1:0] r_x, r_y, r_z;
    logic [CW-1:0] r_dx, r_dy, r_dz;
    logic [CW-1:0] r_nx, r_ny, r_nz;
    logic [CW-1:0] r_prod;
    logic          r_sat;

    // counters
    logic [IDX_W-1:0]     r_step, r_segcnt;
    logic [SEG_NUM_W-1:0] r_segnum;

    // multiplier
    logic [OP_W-1:0]  r_ma;
    logic [BW-1:0]    r_mb;
    logic [PW-1:0]    r_acc;
    logic             r_mneg;
    logic [CNT_W-1:0] r_mcnt;

    // output word
    logic                 r_out_valid;
    logic [CW-1:0]        r_pos_x, r_pos_y, r_pos_z;
    logic [IDX_W-1:0]     r_out_idx;
    logic [COLOR_W-1:0]   r_out_color;
    logic                 r_out_marker, r_out_last, r_out_ovf;

    logic [CW:0]                 w_sub_yx, w_sub_rz, w_wb;
    logic signed [XW-1:0]        w_opa, w_opb;
    logic                        w_opflag;
    logic [OP_W+MUL_CHUNK-1:0]   w_pp;
    logic [QW-1:0]               w_q, w_lim, w_qs;
    logic                        w_qsat;
    logic [CW-1:0]               w_prod;
    logic [IDX_W:0]              w_idx1;
    logic                        w_last;
    logic [IDX_W-1:0]            w_seg1;
    logic [COLOR_W-1:0]          w_color;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho    <= RHO_RST;
            r_sigma  <= SIGMA_RST;
            r_beta   <= BETA_RST;
            r_dt     <= DT_RST;
            r_marker <= MARKER_RST;
            r_seglen <= SEGLEN_RST;
            r_runlen <= RUNLEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RHO:    r_rho    <= i_cfg_data[PARAM_W-1:0];
                CFG_SIGMA:  r_sigma  <= i_cfg_data[PARAM_W-1:0];
                CFG_BETA:   r_beta   <= i_cfg_data[PARAM_W-1:0];
                CFG_DT:     r_dt     <= i_cfg_data[DT_W-1:0];
                CFG_MARKER: r_marker <= i_cfg_data[IDX_W-1:0];
                CFG_SEGLEN: r_seglen <= i_cfg_data[IDX_W-1:0];
                CFG_RUNLEN: r_runlen <= i_cfg_data[IDX_W-1:0];
                default:    r_rho    <= r_rho;
            endcase
        end
    end

    // operand select for the current multiply
    always_comb begin
        w_sub_yx = sat_c(sx(r_y) - sx(r_x));
        w_sub_rz = sat_c($signed({{(XW-PARAM_W){1'b0}}, r_rho}) - sx(r_z));
        w_opflag = 1'b0;
        case (i_cmd.op)
            MOP_SIGMA_DX: begin
                w_opa    = $signed({{(XW-PARAM_W){1'b0}}, r_sigma});
                w_opb    = sx(w_sub_yx[CW-1:0]);
                w_opflag = w_sub_yx[CW];
            end
            MOP_X_RHO: begin
                w_opa    = sx(r_x);
                w_opb    = sx(w_sub_rz[CW-1:0]);
                w_opflag = w_sub_rz[CW];
            end
            MOP_X_Y: begin
                w_opa = sx(r_x);
                w_opb = sx(r_y);
            end
            MOP_BETA_Z: begin
                w_opa = $signed({{(XW-PARAM_W){1'b0}}, r_beta});
                w_opb = sx(r_z);
            end
            MOP_DT_DX: begin
                w_opa = $signed({{(XW-DT_W){1'b0}}, r_dt});
                w_opb = sx(r_dx);
            end
            MOP_DT_DY: begin
                w_opa = $signed({{(XW-DT_W){1'b0}}, r_dt});
                w_opb = sx(r_dy);
            end
            MOP_DT_DZ: begin
                w_opa = $signed({{(XW-DT_W){1'b0}}, r_dt});
                w_opb = sx(r_dz);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // shift-and-add multiplier, one slice of B per cycle, top slice first
    assign w_pp = r_ma * r_mb[BW-1 -: MUL_CHUNK];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= mag(w_opa);
            r_mb   <= BW'(mag(w_opb));
            r_acc  <= '0;
            r_mneg <= w_opa[XW-1] ^ w_opb[XW-1];
            r_mcnt <= CNT_W'(NCH - 1);
        end else if (i_cmd.mul_step) begin
            r_acc  <= (r_acc << MUL_CHUNK) + {{(BW-MUL_CHUNK){1'b0}}, w_pp};
            r_mb   <= r_mb << MUL_CHUNK;
            r_mcnt <= r_mcnt - CNT_W'(1);
        end
    end

    // drop fraction bits, clamp magnitude, apply sign
    always_comb begin
        w_q    = r_acc[PW-1:FRAC_BITS];
        w_lim  = r_mneg ? LIM_NEG : LIM_POS;
        w_qsat = (w_q > w_lim);
        w_qs   = w_qsat ? w_lim : w_q;
        w_prod = r_mneg ? (CW'(0) - w_qs[CW-1:0]) : w_qs[CW-1:0];
    end

    // add/subtract that follows a product (sigma*dx and x*y pass through)
    always_comb begin
        case (i_cmd.op)
            MOP_X_RHO:  w_wb = sat_c(sx(r_prod) - sx(r_y));
            MOP_BETA_Z: w_wb = sat_c(sx(r_dz) - sx(r_prod));
            MOP_DT_DX:  w_wb = sat_c(sx(r_x) + sx(r_prod));
            MOP_DT_DY:  w_wb = sat_c(sx(r_y) + sx(r_prod));
            MOP_DT_DZ:  w_wb = sat_c(sx(r_z) + sx(r_prod));
            default:    w_wb = {1'b0, r_prod};
        endcase
    end

    // product, derivative and new-point registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_prod <= w_prod;
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                MOP_SIGMA_DX: r_dx <= r_prod;
                MOP_X_RHO:    r_dy <= w_wb[CW-1:0];
                MOP_X_Y:      r_dz <= r_prod;
                MOP_BETA_Z:   r_dz <= w_wb[CW-1:0];
                MOP_DT_DX:    r_nx <= w_wb[CW-1:0];
                MOP_DT_DY:    r_ny <= w_wb[CW-1:0];
                MOP_DT_DZ:    r_nz <= w_wb[CW-1:0];
                default:      r_dx <= r_dx;
            endcase
        end
    end

    // overflow tracking over one step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.take) begin
            r_sat <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_sat <= r_sat | w_opflag;
        end else if (i_cmd.norm) begin
            r_sat <= r_sat | w_qsat;
        end else if (i_cmd.wb) begin
            r_sat <= r_sat | w_wb[CW];
        end
    end

    // run and segment bookkeeping
    always_comb begin
        w_idx1  = {1'b0, r_step} + (IDX_W + 1)'(1);
        w_last  = (w_idx1 >= {1'b0, r_runlen});
        w_seg1  = r_segcnt + IDX_W'(1);
        w_color = (r_segnum[SEG_NUM_W-1:1] > COLOR_BLUE) ? COLOR_BLUE
                                                        : r_segnum[SEG_NUM_W-1:1];
    end

    // point and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.take && i_restart) || (i_cmd.commit && w_last)) begin
            r_x      <= ONE_C;
            r_y      <= ONE_C;
            r_z      <= ONE_C;
            r_step   <= '0;
            r_segcnt <= '0;
            r_segnum <= '0;
        end else if (i_cmd.commit) begin
            r_x    <= r_nx;
            r_y    <= r_ny;
            r_z    <= r_nz;
            r_step <= w_idx1[IDX_W-1:0];
            if (w_seg1 >= r_seglen) begin
                r_segcnt <= '0;
                if (r_segnum < SEG_NUM_MAX) begin
                    r_segnum <= r_segnum + SEG_NUM_W'(1);
                end
            end else begin
                r_segcnt <= w_seg1;
            end
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pos_x      <= r_nx;
            r_pos_y      <= r_ny;
            r_pos_z      <= r_nz;
            r_out_idx    <= r_step;
            r_out_color  <= w_color;
            r_out_marker <= (r_step == r_marker);
            r_out_last   <= w_last;
            r_out_ovf    <= r_sat;
        end
    end

    assign o_sts.mul_last = (r_mcnt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_pos_z         = r_pos_z;
    assign o_step_index    = r_out_idx;
    assign o_color_code    = r_out_color;
    assign o_marker_hit    = r_out_marker;
    assign o_last_of_run   = r_out_last;
    assign o_overflow_flag = r_out_ovf;

endmodule

### design/lorenz_euler_stepper.sv
// Channel   Handshake                     Payload
// config    i_cfg_we                      i_cfg_index, i_cfg_data
// input     i_in_valid / o_in_stall       i_restart
// output    o_out_valid / i_out_stall     o_pos_x/y/z, o_step_index, o_color_code,
//                                         o_marker_hit, o_last_of_run, o_overflow_flag
//
// The seven products of a step share one multiplier that consumes a 16-bit slice of its
// second operand per cycle; NCH = ceil(max(COORD_WIDTH, 31) / 16) slices per product.
// Synchronous active-low reset; point returns to (1,1,1), registers to defaults.
// Input is stalled while a word is in work; a finished word waits in the output
// register, and the next input is taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lorenz_euler_stepper
    import les_pkg::*;
#(
    parameter int FRAC_BITS   = LES_FRAC_BITS,
    parameter int COORD_WIDTH = LES_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z,
    output logic [IDX_W-1:0]              o_step_index,
    output logic [COLOR_W-1:0]            o_color_code,
    output logic                          o_marker_hit,
    output logic                          o_last_of_run,
    output logic                          o_overflow_flag
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    les_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // arithmetic, state and output register
    les_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_restart       (i_restart),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_step_index    (o_step_index),
        .o_color_code    (o_color_code),
        .o_marker_hit    (o_marker_hit),
        .o_last_of_run   (o_last_of_run),
        .o_overflow_flag (o_overflow_flag)
    );

    // an accepted word keeps the input stalled next cycle
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

    // a finished word never overwrites one still held at the output
    `ASSERT_SAME(a_commit_free, i_clk, i_rst_n, w_cmd.commit, !o_out_valid || !i_out_stall, "output word overwritten")

    // a finished word shows up as valid output
    `ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, w_cmd.commit, o_out_valid, "committed word not presented")

endmodule
